@@ rtl/oawf_pkg.sv @@
// Package for the optimal arm win frequency block.
// Sequencer state type and fixed field widths; no dependencies.
`default_nettype none

package oawf_pkg;

  localparam int PICK_BITS  = 16;   // random word width, Q16 scale
  localparam int ARM_OUT_W  = 6;    // arm_index field
  localparam int WIN_OUT_W  = 16;   // win_count field
  localparam int FRAC_BITS  = 17;   // win_fraction field, Q16 up to one
  localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'h10000;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,  // take arm values
    ST_MUL  = 8'b0000_0010,  // k = pick * ties >> 16
    ST_SCAN = 8'b0000_0100,  // walk the tie mask for the k-th arm
    ST_WR   = 8'b0000_1000,  // bump the chosen arm, close the row
    ST_ORD  = 8'b0001_0000,  // read one arm's win count
    ST_LOAD = 8'b0010_0000,  // start the divide
    ST_DIV  = 8'b0100_0000,  // wait for the quotient
    ST_OUT  = 8'b1000_0000   // hold the result until taken
  } state_t;

endpackage

`default_nettype wire

@@ rtl/oawf_in_if.sv @@
// Input channel: one sampled arm value per request.
// Depends on oawf_pkg for the random word width.
`default_nettype none

interface oawf_in_if
  import oawf_pkg::*;
#(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;
  logic        [PICK_BITS-1:0]  random_pick;
  logic                         end_of_row;
  logic                         end_of_batch;

  modport source (output valid, element_value, random_pick, end_of_row, end_of_batch,
                  input ready);
  modport sink   (input valid, element_value, random_pick, end_of_row, end_of_batch,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/oawf_out_if.sv @@
// Result channel: one arm's win count and Q16 win fraction per request.
// Depends on oawf_pkg for the field widths.
`default_nettype none

interface oawf_out_if
  import oawf_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ARM_OUT_W-1:0] arm_index;
  logic [WIN_OUT_W-1:0] win_count;
  logic [FRAC_BITS-1:0] win_fraction;
  logic                 last_arm;

  modport source (output valid, arm_index, win_count, win_fraction, last_arm,
                  input ready);
  modport sink   (input valid, arm_index, win_count, win_fraction, last_arm,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/oawf_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module oawf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/oawf_div.sv @@
// Radix-2 restoring divider for the Q16 win fraction: num * 2^16 / den.
// Assumes num <= den (integer part 0 or 1). Uses oawf_pkg.
`default_nettype none

module oawf_div
  import oawf_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CW-1:0]        num,
  input  wire logic [CW-1:0]        den,
  output logic                      done,
  output logic      [FRAC_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(PICK_BITS + 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CW-1:0]        rem_r;
  logic [CW-1:0]        den_r;
  logic [FRAC_BITS-1:0] quo_r;

  logic [CW:0] shifted;
  logic        ge;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};
  assign done    = busy_r && (cnt_r == '0);
  // integer part can only be one when num equals den; guard anyway
  assign quo     = quo_r[FRAC_BITS-1] ? FRAC_ONE : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      den_r  <= den;
      if (den == '0) begin
        cnt_r <= '0;
        quo_r <= '0;
        rem_r <= '0;
      end else begin
        cnt_r <= CNT_W'(PICK_BITS);
        quo_r <= {{(FRAC_BITS-1){1'b0}}, (num >= den)};
        rem_r <= (num >= den) ? (num - den) : num;
      end
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        quo_r <= {quo_r[FRAC_BITS-2:0], ge};
        rem_r <= ge ? CW'(shifted - {1'b0, den_r}) : shifted[CW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/optimal_arm_win_frequency_top.sv @@
// Optimal arm win frequency: Monte Carlo best-arm tally with random tie break.
// Plain arm value: accepted while the sequencer idles. Row end: a sequence of steps
// (accept, multiply, tie-mask walk one bit a cycle, table write).
// Batch end, per arm: RAM read, divider start, divide, out with its output wait.
// in ready only while the sequencer idles; one request in flight at a time.
// Reset (sync, rst_n low): row state, valid bits of the win table and row count clear at once.
// Depends on oawf_pkg, oawf_in_if, oawf_out_if, oawf_ram, oawf_div.
`default_nettype none

module optimal_arm_win_frequency_top
  import oawf_pkg::*;
#(
  parameter int ARM_COUNT  = 16,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  oawf_in_if.sink    in_if,
  oawf_out_if.source out_if
);

  localparam int IDX_BITS = $clog2(ARM_COUNT);
  localparam int TOT_BITS = $clog2(ARM_COUNT + 1);
  localparam int PROD_W   = PICK_BITS + TOT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t state_r, state_nxt;

  // row state
  logic signed [VALUE_BITS-1:0] run_max_r;
  logic [ARM_COUNT-1:0]         tie_mask_r;
  logic [TOT_BITS-1:0]          tie_total_r;
  logic [TOT_BITS-1:0]          pos_r;
  logic [PICK_BITS-1:0]         pick_r;
  logic                         batch_r;

  // tie walk
  logic [TOT_BITS-1:0]  k_r;
  logic [ARM_COUNT-1:0] scan_mask_r;
  logic [IDX_BITS-1:0]  scan_idx_r;
  logic                 hit_r;
  logic [IDX_BITS-1:0]  win_idx_r;

  // batch state; win table entries read as zero until their valid bit is set
  logic [COUNT_BITS-1:0] rows_r;
  logic [ARM_COUNT-1:0]  vld_r;
  logic [IDX_BITS-1:0]   arm_r;
  logic [COUNT_BITS-1:0] wins_r;

  // output register
  logic                 out_valid_r;
  logic [WIN_OUT_W-1:0] out_win_r;
  logic [FRAC_BITS-1:0] out_frac_r;

  logic in_acc, out_acc;
  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_valid_r && out_if.ready;

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.arm_index    = ARM_OUT_W'(arm_r);
  assign out_if.win_count    = out_win_r;
  assign out_if.win_fraction = out_frac_r;
  assign out_if.last_arm     = (arm_r == IDX_BITS'(ARM_COUNT - 1));

  // ---- tracking of one arm value ----
  logic                in_range;
  logic [IDX_BITS-1:0] pos_idx;
  assign in_range = pos_r < TOT_BITS'(ARM_COUNT);
  assign pos_idx  = pos_r[IDX_BITS-1:0];

  // ---- tie index: k = (pick * ties) >> 16, always below ties ----
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(pick_r) * PROD_W'(tie_total_r);

  // ---- win table ----
  logic                  ram_we, ram_re;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata, ram_wdata;
  logic [COUNT_BITS-1:0] win_cur, arm_cur;
  logic                  scan_take;

  assign scan_take = scan_mask_r[0] && (k_r == '0);
  assign win_cur   = vld_r[win_idx_r] ? ram_rdata : '0;
  assign arm_cur   = vld_r[arm_r] ? ram_rdata : '0;
  assign ram_we    = (state_r == ST_WR) && hit_r;
  assign ram_wdata = (win_cur == CNT_MAX) ? win_cur : win_cur + 1'b1;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = arm_r;
    unique case (state_r)
      ST_SCAN: begin
        ram_re    = scan_take;
        ram_raddr = scan_idx_r;
      end
      ST_ORD:  ram_re = 1'b1;
      default: ;
    endcase
  end

  oawf_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (ARM_COUNT)
  ) u_wins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (win_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- shared divider for the Q16 fraction ----
  logic                 div_start, div_done;
  logic [FRAC_BITS-1:0] div_quo;
  assign div_start = (state_r == ST_LOAD);

  oawf_div #(
    .CW (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (arm_cur),
    .den   (rows_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && (in_if.end_of_row || in_if.end_of_batch)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SCAN;
      ST_SCAN: if (scan_take || (scan_mask_r == '0)) state_nxt = ST_WR;
      ST_WR:   state_nxt = batch_r ? ST_ORD : ST_IDLE;
      ST_ORD:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = out_if.last_arm ? ST_IDLE : ST_ORD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_max_r   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
      tie_mask_r  <= '0;
      tie_total_r <= '0;
      pos_r       <= '0;
      batch_r     <= 1'b0;
      rows_r      <= '0;
      vld_r       <= '0;
      arm_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pick_r  <= in_if.random_pick;
            batch_r <= in_if.end_of_batch;
            if (in_range) begin
              // first arm of a row always opens a fresh tie set
              if ((pos_r == '0) || (in_if.element_value > run_max_r)) begin
                run_max_r   <= in_if.element_value;
                tie_mask_r  <= {{(ARM_COUNT-1){1'b0}}, 1'b1} << pos_idx;
                tie_total_r <= TOT_BITS'(1);
              end else if (in_if.element_value == run_max_r) begin
                tie_mask_r[pos_idx] <= 1'b1;
                tie_total_r        <= tie_total_r + 1'b1;
              end
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        ST_MUL: begin
          k_r         <= prod[PICK_BITS +: TOT_BITS];
          scan_mask_r <= tie_mask_r;
          scan_idx_r  <= '0;
        end
        ST_SCAN: begin
          if (scan_take) begin
            hit_r     <= 1'b1;
            win_idx_r <= scan_idx_r;
          end else if (scan_mask_r == '0) begin
            hit_r <= 1'b0;
          end else begin
            if (scan_mask_r[0]) begin
              k_r <= k_r - 1'b1;
            end
            scan_mask_r <= scan_mask_r >> 1;
            scan_idx_r  <= scan_idx_r + 1'b1;
          end
        end
        ST_WR: begin
          if (hit_r) begin
            vld_r[win_idx_r] <= 1'b1;
          end
          if (rows_r != CNT_MAX) begin
            rows_r <= rows_r + 1'b1;
          end
          run_max_r   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
          tie_mask_r  <= '0;
          tie_total_r <= '0;
          pos_r       <= '0;
          scan_mask_r <= '0;
          hit_r       <= 1'b0;
          arm_r       <= '0;
        end
        ST_ORD: ;
        ST_LOAD: wins_r <= arm_cur;
        ST_DIV: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            out_win_r   <= WIN_OUT_W'(wins_r);
            out_frac_r  <= div_quo;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (out_if.last_arm) begin
              // batch done: clear the table and row count
              vld_r   <= '0;
              rows_r  <= '0;
              batch_r <= 1'b0;
            end else begin
              arm_r <= arm_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---- checks ----
  a_tie_count: assert property (@(posedge clk) disable iff (!rst_n)
    tie_total_r == $countones(tie_mask_r))
    else $error("tie count disagrees with tie mask");

  a_tie_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    tie_total_r <= pos_r)
    else $error("more ties than arms seen");

  a_rows_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (rows_r != '0))
    else $error("fraction requested with zero rows");

  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_if.last_arm) |=> ((state_r == ST_IDLE) && (vld_r == '0)))
    else $error("batch not cleared after last arm");

endmodule

`default_nettype wire

@@ tb/oawf_win_checker.sv @@
// Checker for the optimal arm win frequency block: tracks each row's peak and ties,
// keeps its own win table and compares every per-arm result with the due tally.
// Depends on oawf_pkg, oawf_in_if and oawf_out_if.
`default_nettype none

module oawf_win_checker
  import oawf_pkg::*;
#(
  parameter int ARM_COUNT  = 16,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  oawf_in_if       in_mon,
  oawf_out_if      out_mon,
  output int       fail_count,
  output int       results_due
);

  typedef struct packed {
    logic [ARM_OUT_W-1:0] arm_index;
    logic [WIN_OUT_W-1:0] win_count;
    logic [FRAC_BITS-1:0] win_fraction;
    logic                 last_arm;
  } arm_tally_t;

  arm_tally_t tally_due[$];

  // row and batch state
  logic signed [VALUE_BITS-1:0] row_peak;
  logic [ARM_COUNT-1:0]         peak_ties;
  int unsigned                  tie_cnt;
  int unsigned                  arm_pos;
  logic [COUNT_BITS-1:0]        win_tab [ARM_COUNT];
  logic [COUNT_BITS-1:0]        row_cnt;

  initial fail_count = 0;

  task automatic clear_row();
    row_peak  = '0;
    peak_ties = '0;
    tie_cnt   = 0;
    arm_pos   = 0;
  endtask

  task automatic clear_batch();
    clear_row();
    for (int a = 0; a < ARM_COUNT; a++) win_tab[a] = '0;
    row_cnt = '0;
  endtask

  task automatic take_sample(input logic signed [VALUE_BITS-1:0] val,
                             input logic [PICK_BITS-1:0] pick,
                             input logic eor, input logic eob);
    int unsigned nth;
    bit          chosen;
    logic [63:0] quot;
    arm_tally_t  t;
    // first arm always opens the tie set; arms past the table are dropped
    if (arm_pos < ARM_COUNT) begin
      if (arm_pos == 0 || val > row_peak) begin
        row_peak  = val;
        peak_ties = '0;
        peak_ties[arm_pos] = 1'b1;
        tie_cnt   = 1;
      end else if (val == row_peak) begin
        peak_ties[arm_pos] = 1'b1;
        tie_cnt++;
      end
      arm_pos++;
    end
    if (eor || eob) begin
      nth    = (32'(pick) * tie_cnt) >> PICK_BITS;
      chosen = 1'b0;
      for (int p = 0; p < ARM_COUNT; p++) begin
        if (!chosen && peak_ties[p]) begin
          if (nth == 0) begin
            chosen = 1'b1;
            if (win_tab[p] != '1) win_tab[p]++;
          end else begin
            nth--;
          end
        end
      end
      if (row_cnt != '1) row_cnt++;
      clear_row();
    end
    if (eob) begin
      for (int a = 0; a < ARM_COUNT; a++) begin
        quot = '0;
        if (row_cnt != '0) quot = (64'(win_tab[a]) << 16) / 64'(row_cnt);
        if (quot > 64'(FRAC_ONE)) quot = 64'(FRAC_ONE);
        t.arm_index    = ARM_OUT_W'(a);
        t.win_count    = WIN_OUT_W'(win_tab[a]);
        t.win_fraction = quot[FRAC_BITS-1:0];
        t.last_arm     = (a == ARM_COUNT - 1);
        tally_due.insert(tally_due.size(), t);
      end
      clear_batch();
    end
  endtask

  task automatic check_result();
    arm_tally_t got;
    arm_tally_t want;
    got = {out_mon.arm_index, out_mon.win_count, out_mon.win_fraction, out_mon.last_arm};
    if (tally_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result arm %0d wins %0d frac %0d last %0d", $realtime,
                 got.arm_index, got.win_count, got.win_fraction, got.last_arm);
    end else begin
      want = tally_due.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch exp arm %0d wins %0d frac %0d last %0d, got arm %0d wins %0d frac %0d last %0d",
                   $realtime, want.arm_index, want.win_count, want.win_fraction,
                   want.last_arm, got.arm_index, got.win_count, got.win_fraction,
                   got.last_arm);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_batch();
      tally_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        take_sample(in_mon.element_value, in_mon.random_pick, in_mon.end_of_row,
                    in_mon.end_of_batch);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    results_due = tally_due.size();
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench top for optimal_arm_win_frequency_top: clock, reset, request stimulus and
// random result back-pressure; prediction and comparison live in oawf_win_checker.
// Depends on oawf_pkg, oawf_in_if, oawf_out_if, oawf_win_checker and the block itself.
`default_nettype none

module tb;
  import oawf_pkg::*;

  localparam int ARM_COUNT  = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;

  localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  localparam int RAND_ITEMS = 155;
  localparam int HOLD_LEN   = 400;   // receiver hold-off, cycles
  localparam int DRAIN_WAIT = 400;   // settle wait after the results have drained

  logic clk;
  logic rst_n;

  // calm: no idling on either side; hold_req: receiver starts a long hold-off
  bit calm;
  bit hold_req;

  int fail_count;
  int results_due;

  oawf_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  oawf_out_if out_ch ();

  optimal_arm_win_frequency_top #(
    .ARM_COUNT (ARM_COUNT),
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  oawf_win_checker #(
    .ARM_COUNT (ARM_COUNT),
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, even with every request ending a batch.
  initial begin
    #(64'd12 * 64'd500_000);
    $display("Regression FAIL");
    $finish;
  end

  // Result side. Ready changes only at the falling edge. A hold request forces
  // ready low while the HOLD_LEN countdown runs, so the block backs up into its input.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 34);
      end
    end
  end

  // Mix of tie-prone small values, both extremes and full-range words.
  function automatic logic signed [VALUE_BITS-1:0] draw_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) draw_value = $signed(VALUE_BITS'($urandom_range(3))) - 2;
    else if (r < 55) draw_value = V_MAX;
    else if (r < 65) draw_value = V_MIN;
    else draw_value = $urandom;
  endfunction

  // Entered at a falling edge, returns at the falling edge after acceptance
  // with valid still high; valid drops only for random idling when not calm.
  task automatic send_sample(input logic signed [VALUE_BITS-1:0] val,
                             input logic [PICK_BITS-1:0] pick,
                             input bit eor, input bit eob);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.element_value = val;
    in_ch.random_pick   = pick;
    in_ch.end_of_row    = eor;
    in_ch.end_of_batch  = eob;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int batch_no;
    int rows;
    int len;
    bit row_last;
    bit batch_last;

    rst_n               = 1'b0;
    calm                = 1'b0;
    hold_req            = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    in_ch.random_pick   = '0;
    in_ch.end_of_row    = 1'b0;
    in_ch.end_of_batch  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed batch: four rows, one win each for arms 0, 2, 3, 8 ---
    // single-arm row holding the top value, lowest pick
    send_sample(V_MAX, 16'h0000, 1'b1, 1'b0);
    // row of bottom values: first arm must still seed the tie set;
    // top pick selects the last of three ties
    send_sample(V_MIN, 16'hFFFF, 1'b0, 1'b0);
    send_sample(V_MIN, 16'hFFFF, 1'b0, 1'b0);
    send_sample(V_MIN, 16'hFFFF, 1'b1, 1'b0);
    // non-adjacent ties on arms 1 and 3
    send_sample(-1, 16'h1234, 1'b0, 1'b0);
    send_sample(5, 16'h1234, 1'b0, 1'b0);
    send_sample(0, 16'h1234, 1'b0, 1'b0);
    send_sample(5, 16'hFFFF, 1'b1, 1'b0);
    // sixteen-way tie plus one surplus arm that must be ignored; the
    // batch ends on that surplus arm without a row-end flag
    for (int i = 0; i < ARM_COUNT; i++) send_sample(7, 16'h8000, 1'b0, 1'b0);
    send_sample(7, 16'h8000, 1'b0, 1'b1);
    // one-row batch with both end flags set together
    send_sample(V_MIN, 16'(($urandom)), 1'b1, 1'b1);

    // --- random batches ---
    sent     = 0;
    batch_no = 0;
    while (sent < RAND_ITEMS) begin
      // batches 2 and 3 run with no random idling on either side
      calm = (batch_no >= 2 && batch_no <= 3);
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        len = ($urandom_range(99) < 80) ? $urandom_range(1, ARM_COUNT)
                                        : $urandom_range(ARM_COUNT + 1, ARM_COUNT + 4);
        for (int e = 0; e < len; e++) begin
          row_last   = (e == len - 1);
          batch_last = row_last && (r == rows - 1);
          // long receiver hold-off over the readout while requests keep coming
          if (batch_last && batch_no == 1) hold_req = 1'b1;
          // batch end sometimes arrives without the row-end flag
          send_sample(draw_value(), 16'($urandom),
                      batch_last ? bit'($urandom_range(1)) : row_last, batch_last);
          sent++;
        end
      end
      if (batch_no == 3) begin
        // sender pause until the readout has fully drained
        in_ch.valid = 1'b0;
        wait (results_due == 0);
        @(negedge clk);
      end
      batch_no++;
    end
    calm        = 1'b0;
    in_ch.valid = 1'b0;

    wait (results_due == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/oawf_pkg.sv
rtl/oawf_in_if.sv
rtl/oawf_out_if.sv
rtl/oawf_ram.sv
rtl/oawf_div.sv
rtl/optimal_arm_win_frequency_top.sv
tb/oawf_win_checker.sv
tb/tb.sv
